// ===== hw/rtl/bqlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared widths, codes and control types of the biquad low-pass section.
// ----------------------------------------------------------------------------
package bqlp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int STATE_W    = 48;
    localparam int COEF_SHIFT = COEF_W - 3;          // Q3.15 -> 15 fraction bits
    localparam int YQ_W       = SAMPLE_W + 1;        // fed-back y, +-2 range
    localparam int PROD_W     = COEF_W + YQ_W;       // coef * (x or yq)
    localparam int SUM_W      = STATE_W + 1;         // adder with guard bit
    localparam int RY_W       = SUM_W - COEF_SHIFT;  // y rounded to sample scale
    localparam int RO_W       = SUM_W - COEF_SHIFT - 1; // y/2 rounded
    localparam int NUM_COEFS  = 5;
    localparam int CFG_IDX_W  = 3;

    // Register indexes, also used as coefficient select of the multiplier.
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MB0,
        S_ADDY,
        S_RNDQ,
        S_MOVE,
        S_SUB1,
        S_WB,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        ADD_NONE,   // adder result unused
        ADD_Y,      // y    = z1 + b0*x
        ADD_ACC,    // acc  = z2 + b1*x
        ADD_SUB,    // acc  = acc - a1*yq
        ADD_Z2      // z2'  = b2*x - a2*yq, z1' = acc
    } t_add_op;

    typedef struct packed {
        logic      load_x;
        logic      mul_en;
        t_coef_idx coef_sel;
        logic      mul_use_yq;
        t_add_op   add_op;
        logic      load_q;
        logic      move_t;
        logic      load_out;
    } t_ctl;

endpackage

// ===== hw/rtl/bqlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqlp_ctrl
// Sequencer: steps the shared multiplier and adder through one sample.
// ----------------------------------------------------------------------------
module bqlp_ctrl
    import bqlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_free,
    output logic o_busy,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MB0;
                end
            end
            S_MB0:  n_state = S_ADDY;
            S_ADDY: n_state = S_RNDQ;
            S_RNDQ: n_state = S_MOVE;
            S_MOVE: n_state = S_SUB1;
            S_SUB1: n_state = S_WB;
            S_WB:   n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.coef_sel   = COEF_B0;
        o_ctl.add_op     = ADD_NONE;
        o_busy           = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load_x = i_in_valid;
            end
            S_MB0: begin
                o_ctl.mul_en   = 1'b1;
                o_ctl.coef_sel = COEF_B0;
            end
            S_ADDY: begin
                o_ctl.add_op   = ADD_Y;
                o_ctl.mul_en   = 1'b1;
                o_ctl.coef_sel = COEF_B1;
            end
            S_RNDQ: begin
                o_ctl.load_q   = 1'b1;
                o_ctl.add_op   = ADD_ACC;
                o_ctl.mul_en   = 1'b1;
                o_ctl.coef_sel = COEF_B2;
            end
            S_MOVE: begin
                o_ctl.move_t     = 1'b1;
                o_ctl.mul_en     = 1'b1;
                o_ctl.coef_sel   = COEF_A1;
                o_ctl.mul_use_yq = 1'b1;
            end
            S_SUB1: begin
                o_ctl.add_op     = ADD_SUB;
                o_ctl.mul_en     = 1'b1;
                o_ctl.coef_sel   = COEF_A2;
                o_ctl.mul_use_yq = 1'b1;
            end
            S_WB: begin
                o_ctl.add_op = ADD_Z2;
            end
            S_OUT: begin
                o_ctl.load_out = i_out_free;
            end
            default: begin
                o_ctl.load_x = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bqlp_dp.sv =====
// ----------------------------------------------------------------------------
// bqlp_dp
// Datapath: one multiplier, one saturating adder, delay state, rounding.
// ----------------------------------------------------------------------------
module bqlp_dp
    import bqlp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [COEF_W-1:0]   i_coef [NUM_COEFS],
    output logic signed [SAMPLE_W-1:0] o_result
);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_t;
    logic signed [STATE_W-1:0]  r_y;
    logic signed [STATE_W-1:0]  r_acc;
    logic signed [STATE_W-1:0]  r_z1;
    logic signed [STATE_W-1:0]  r_z2;
    logic signed [YQ_W-1:0]     r_yq;
    logic signed [SAMPLE_W-1:0] r_res;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [YQ_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [SUM_W-1:0]    add_a;
    logic signed [SUM_W-1:0]    add_b;
    logic                       add_sub;
    logic signed [SUM_W-1:0]    add_raw;
    logic signed [STATE_W-1:0]  add_sat;
    logic signed [SUM_W-1:0]    rnd_y;
    logic signed [SUM_W-1:0]    rnd_o;
    logic        [RY_W-1:0]     ry;
    logic        [RO_W-1:0]     ro;
    logic signed [YQ_W-1:0]     yq_sat;
    logic signed [SAMPLE_W-1:0] out_sat;

    // multiplier operand select
    always_comb begin
        unique case (i_ctl.coef_sel)
            COEF_B0: mul_a = i_coef[0];
            COEF_B1: mul_a = i_coef[1];
            COEF_B2: mul_a = i_coef[2];
            COEF_A1: mul_a = i_coef[3];
            COEF_A2: mul_a = i_coef[4];
            default: mul_a = '0;
        endcase
        mul_b = i_ctl.mul_use_yq ? r_yq : {r_x[SAMPLE_W-1], r_x};
        mul_p = mul_a * mul_b;
    end

    // saturating adder; every operand fits, so one guard bit shows overflow
    always_comb begin
        add_sub = 1'b0;
        add_a   = '0;
        add_b   = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        case (i_ctl.add_op)
            ADD_Y:   add_a = {r_z1[STATE_W-1], r_z1};
            ADD_ACC: add_a = {r_z2[STATE_W-1], r_z2};
            ADD_SUB: begin
                add_a   = {r_acc[STATE_W-1], r_acc};
                add_sub = 1'b1;
            end
            ADD_Z2: begin
                add_a   = {{(SUM_W-PROD_W){r_t[PROD_W-1]}}, r_t};
                add_sub = 1'b1;
            end
            default: add_a = '0;
        endcase
        add_raw = add_sub ? (add_a - add_b) : (add_a + add_b);
        if (add_raw[SUM_W-1] != add_raw[SUM_W-2]) begin
            add_sat = {add_raw[SUM_W-1], {(STATE_W-1){~add_raw[SUM_W-1]}}};
        end else begin
            add_sat = add_raw[STATE_W-1:0];
        end
    end

    // round half up, then clamp: y to +-2 for feedback, y/2 to the sample range
    always_comb begin
        rnd_y = {r_y[STATE_W-1], r_y} + (SUM_W'(1) << (COEF_SHIFT - 1));
        rnd_o = {r_y[STATE_W-1], r_y} + (SUM_W'(1) << COEF_SHIFT);
        ry    = rnd_y[SUM_W-1:COEF_SHIFT];
        ro    = rnd_o[SUM_W-1:COEF_SHIFT+1];
        if ((&ry[RY_W-1:YQ_W-1]) || !(|ry[RY_W-1:YQ_W-1])) begin
            yq_sat = ry[YQ_W-1:0];
        end else begin
            yq_sat = {ry[RY_W-1], {(YQ_W-1){~ry[RY_W-1]}}};
        end
        if ((&ro[RO_W-1:SAMPLE_W-1]) || !(|ro[RO_W-1:SAMPLE_W-1])) begin
            out_sat = ro[SAMPLE_W-1:0];
        end else begin
            out_sat = {ro[RO_W-1], {(SAMPLE_W-1){~ro[RO_W-1]}}};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_x) begin
            r_x <= i_sample;
        end
        if (i_ctl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctl.move_t) begin
            r_t <= r_prod;
        end
        if (i_ctl.load_q) begin
            r_yq  <= yq_sat;
            r_res <= out_sat;
        end
        if (i_ctl.add_op == ADD_Y) begin
            r_y <= add_sat;
        end
        if (i_ctl.add_op == ADD_ACC || i_ctl.add_op == ADD_SUB) begin
            r_acc <= add_sat;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= '0;
            r_z2 <= '0;
        end else if (i_ctl.add_op == ADD_Z2) begin
            r_z1 <= r_acc;
            r_z2 <= add_sat;
        end
    end

    assign o_result = r_res;

endmodule

// ===== hw/rtl/biquad_lowpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Second-order IIR section, transposed direct form II, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_in_valid / o_in_stall, payload i_sample_in (Q1.15).
//                    A request is taken when valid is high and stall low.
//   Output channel : o_out_valid / i_out_stall, payload o_sample_out, which
//                    is half the filtered sample, rounded and saturated.
//   Config channel : i_cfg_valid / o_cfg_ready with i_cfg_index and
//                    i_cfg_data (Q3.15). Index 0..4 = b0, b1, b2, a1, a2;
//                    other indexes are dropped. Write only while idle.
//   Timing: one sample at a time. The shared 18x17 multiplier does five
//   products in sequence and one saturating adder does four sums; the
//   sequencer holds o_in_stall high from the accept until the result is
//   handed to the output register; o_out_valid rises when that register
//   takes the result.
//   If the receiver stalls with a result still held, the sequencer waits in
//   its last step until the output register frees up, then goes idle.
//   Reset (synchronous, active low) zeroes both delay registers, sets
//   b0 = 1.0 and the other coefficients to 0, and empties the output.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter
    import bqlp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    // sample output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    // coefficient writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic signed [COEF_W-1:0]   i_cfg_data
);

    logic signed [COEF_W-1:0]   r_coef [NUM_COEFS];
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    t_ctl                       ctl;
    logic                       busy;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] dp_result;

    // output slot is free when empty or being drained this cycle
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    // coefficient registers; b0 resets to unity gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_W'(1) << COEF_SHIFT;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                COEF_B0: r_coef[0] <= i_cfg_data;
                COEF_B1: r_coef[1] <= i_cfg_data;
                COEF_B2: r_coef[2] <= i_cfg_data;
                COEF_A1: r_coef[3] <= i_cfg_data;
                COEF_A2: r_coef[4] <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    bqlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    bqlp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (i_sample_in),
        .i_coef   (r_coef),
        .o_result (dp_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_out_data <= dp_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    // accepted request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input accepted but block not busy next cycle");

    // never overwrite a result that is held by the receiver
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.load_out && r_out_valid && i_out_stall)
    ) else $error("output register overwritten while stalled");

    // a new result only comes from the sequencer's handoff
    a_valid_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctl.load_out)
    ) else $error("output valid rose without a handoff");

    // handoff only while busy, so each accept yields one result
    a_load_when_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_out |-> busy
    ) else $error("handoff while idle");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the biquad low-pass section: random and directed
// samples under coefficient sets, checked against an in-bench fixed-point
// model of the transposed direct form II datapath.
// ----------------------------------------------------------------------------
module tb_top;

    import bqlp_pkg::*;

    // Q3.15 coefficient rails and the common unity gain
    localparam int COEF_TOP  = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_BOT  = -(1 << (COEF_W - 1));
    localparam int COEF_UNIT = 1 << COEF_SHIFT;

    // Q1.15 sample rails
    localparam int SMP_TOP = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SMP_BOT = -(1 << (SAMPLE_W - 1));

    // saturation bounds of the datapath
    localparam longint ST_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint ST_MIN  = -ST_MAX - 1;
    localparam longint YQ_MAX  = (longint'(1) <<< SAMPLE_W) - 1;
    localparam longint YQ_MIN  = -(longint'(1) <<< SAMPLE_W);
    localparam longint OUT_MAX = SMP_TOP;
    localparam longint OUT_MIN = SMP_BOT;

    localparam int HOLD_CYCLES  = 300;     // long output hold-off
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE_TICKS = 20;

    // ------------------------------------------------------------------------
    // clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic signed [COEF_W-1:0]   i_cfg_data  = '0;

    initial forever #5 i_clk = ~i_clk;

    biquad_lowpass_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // filter model: coefficients and the two delay registers, reset values
    longint coef_val [NUM_COEFS] = '{COEF_UNIT, 0, 0, 0, 0};
    longint z1_acc = 0;
    longint z2_acc = 0;

    logic signed [SAMPLE_W-1:0] sample_q   [$];  // samples not yet offered
    logic signed [SAMPLE_W-1:0] filtered_q [$];  // outputs still to arrive

    int  pushed      = 0;   // samples queued so far
    int  accepted    = 0;   // input requests taken by the DUT
    int  checked     = 0;   // output requests compared
    int  mismatches  = 0;
    int  coef_sets   = 0;
    bit  in_taken    = 1'b0;

    // idling knobs, set per phase by the sequence below
    int  in_idle_pct  = 0;
    int  out_idle_pct = 0;
    int  in_gap       = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    int  hold_req     = 0;  // bumped to ask for one long hold-off
    int  hold_seen    = 0;

    logic signed [SAMPLE_W-1:0] exp_out;

    // ------------------------------------------------------------------------
    // fixed-point model of one filter step
    // ------------------------------------------------------------------------
    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat48(longint v);
        return clip(v, ST_MIN, ST_MAX);
    endfunction

    // add half an LSB, then floor (>>> on a signed longint floors)
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // y = b0*x + z1; z2' = b2*x - a2*yq; z1' = z2 + b1*x - a1*yq; out = y/2
    function automatic logic signed [SAMPLE_W-1:0] lowpass_step(
        logic signed [SAMPLE_W-1:0] x_in
    );
        longint x;
        longint y;
        longint yq;
        longint nz1;
        longint nz2;
        longint o;
        x   = x_in;
        y   = sat48(sat48(coef_val[COEF_B0] * x) + z1_acc);
        // feedback uses y at sample scale, limited to +-2
        yq  = clip(rnd_shift(y, COEF_SHIFT), YQ_MIN, YQ_MAX);
        nz2 = sat48(sat48(coef_val[COEF_B2] * x) - sat48(coef_val[COEF_A2] * yq));
        nz1 = sat48(sat48(z2_acc + sat48(coef_val[COEF_B1] * x))
                    - sat48(coef_val[COEF_A1] * yq));
        // output is the full-precision y, halved and rounded
        o   = clip(rnd_shift(y, COEF_SHIFT + 1), OUT_MIN, OUT_MAX);
        z1_acc = nz1;
        z2_acc = nz2;
        return o[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            // results first: the one leaving now belongs to an older sample
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    $error("sample_out: no output pending, got %0d", o_sample_out);
                    mismatches++;
                end else begin
                    exp_out = filtered_q.pop_front();
                    if (o_sample_out !== exp_out) begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               exp_out, o_sample_out);
                        mismatches++;
                    end
                    checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                filtered_q.push_back(lowpass_step(i_sample_in));
                accepted++;
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input driver: offers queued samples, with random idle bursts
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // stalled request: hold valid and payload
        end else if (in_gap != 0) begin
            in_gap     <= in_gap - 1;
            i_in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
            if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
                in_gap     <= $urandom_range(0, 14);   // start an idle burst
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid  <= 1'b1;
                i_sample_in <= sample_q.pop_front();
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // output stall: random bursts, plus long hold-offs on request so that
    // the output register fills and the DUT backs up its input
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------------
    // one config request; only issued while the filter is idle
    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_COEFS)
            coef_val[idx] = val;    // spare indexes are dropped by the DUT
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
        write_coef(COEF_B0, b0);
        write_coef(COEF_B1, b1);
        write_coef(COEF_B2, b2);
        write_coef(COEF_A1, a1);
        write_coef(COEF_A2, a2);
        coef_sets++;
    endtask

    // call only at a rising edge, away from the driver's falling-edge pops
    function automatic void push_sample(logic signed [SAMPLE_W-1:0] x);
        sample_q.push_back(x);
        pushed++;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_W'(SMP_BOT);
                1:       return SAMPLE_W'(SMP_TOP);
                2:       return '0;
                default: return '1;
            endcase
        end else if (sel <= 3) begin
            return SAMPLE_W'(int'($urandom_range(0, 1024)) - 512);  // quiet passage
        end
        return SAMPLE_W'($urandom);
    endfunction

    // wait until every offered sample has come back out
    task automatic drain();
        while (accepted != pushed || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int a1;
        int a2;
        int lim;
        bit wild;
        bit quiet;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients (unity b0): rails, zero and rounding around 0
        @(posedge i_clk);
        in_idle_pct  = 25;
        out_idle_pct = 25;
        push_sample(SAMPLE_W'(SMP_TOP));
        push_sample(SAMPLE_W'(SMP_BOT));
        push_sample(SAMPLE_W'(0));
        push_sample(SAMPLE_W'(1));
        push_sample(SAMPLE_W'(-1));
        push_sample(SAMPLE_W'(16384));
        push_sample(SAMPLE_W'(-16385));
        push_sample(SAMPLE_W'(2));
        drain();

        // writes to spare indexes must leave the filter untouched
        for (int k = NUM_COEFS; k < (1 << CFG_IDX_W); k++)
            write_coef(CFG_IDX_W'(k), COEF_W'($urandom) | COEF_W'(1));
        @(posedge i_clk);
        push_sample(SAMPLE_W'(SMP_TOP));
        push_sample(SAMPLE_W'(SMP_BOT));
        drain();

        // b0 at its top rail: y near +-4 saturates both yq and the output
        load_coefs(COEF_W'(COEF_TOP), '0, '0, '0, '0);
        @(posedge i_clk);
        push_sample(SAMPLE_W'(SMP_TOP));
        push_sample(SAMPLE_W'(SMP_BOT));
        push_sample(SAMPLE_W'(8192));
        drain();

        // b0 at its bottom rail
        load_coefs(COEF_W'(COEF_BOT), '0, '0, '0, '0);
        @(posedge i_clk);
        push_sample(SAMPLE_W'(SMP_BOT));
        push_sample(SAMPLE_W'(SMP_TOP));
        push_sample(SAMPLE_W'(-1));
        drain();

        // every coefficient on a rail: heavy feedback, clipped yq
        load_coefs(COEF_W'(COEF_TOP), COEF_W'(COEF_BOT), COEF_W'(COEF_TOP),
                   COEF_W'(COEF_BOT), COEF_W'(COEF_TOP));
        @(posedge i_clk);
        repeat (3) push_sample(SAMPLE_W'(SMP_TOP));
        repeat (3) push_sample(SAMPLE_W'(SMP_BOT));
        repeat (2) push_sample(SAMPLE_W'(0));
        drain();

        // random part: mostly stable sections, some with raw random words
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiet = (ph == RAND_PHASES - 1);
            wild  = !quiet && (ph % 3 == 1);
            if (wild) begin
                load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                           COEF_W'($urandom), COEF_W'($urandom));
            end else begin
                // poles inside the stability triangle, with some margin
                a2  = int'($urandom_range(0, 62000)) - 31000;
                lim = (COEF_UNIT + a2) * 19 / 20;
                a1  = int'($urandom_range(0, 2 * lim)) - lim;
                load_coefs(COEF_W'(int'($urandom_range(0, 2 * COEF_UNIT)) - COEF_UNIT),
                           COEF_W'(int'($urandom_range(0, 2 * COEF_UNIT)) - COEF_UNIT),
                           COEF_W'(int'($urandom_range(0, 2 * COEF_UNIT)) - COEF_UNIT),
                           COEF_W'(a1), COEF_W'(a2));
            end
            @(posedge i_clk);
            if (quiet) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if (ph == 1 || ph == 5) begin
                // sender keeps offering while the receiver holds off
                in_idle_pct  = 0;
                out_idle_pct = 10;
                hold_req++;
            end else begin
                in_idle_pct  = $urandom_range(0, 2) * 20;
                out_idle_pct = $urandom_range(0, 2) * 20;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_sample(pick_sample());
            drain();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("checked %0d filtered samples over %0d coefficient sets, %0d long hold-offs",
                 checked, coef_sets, hold_req);
        $display("spare config indexes, rail coefficients and saturating inputs included");
        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
